FILE: rtl/osdfb_pkg.sv
package osdfb_pkg;

   // Command kinds carried by a request word.
   localparam logic [2:0] KIND_ERASE     = 3'd0;
   localparam logic [2:0] KIND_SET_PIXEL = 3'd1;
   localparam logic [2:0] KIND_FONT_LOAD = 3'd2;
   localparam logic [2:0] KIND_DRAW_CHAR = 3'd3;
   localparam logic [2:0] KIND_READ_BYTE = 3'd4;

   // Frame pixel codes.
   localparam logic [1:0] CODE_BLACK       = 2'b00;
   localparam logic [1:0] CODE_TRANSPARENT = 2'b01;
   localparam logic [1:0] CODE_WHITE       = 2'b11;

   // Glyph pixel codes that map to an opaque colour.
   localparam logic [1:0] GLYPH_BLACK = 2'b00;
   localparam logic [1:0] GLYPH_WHITE = 2'b10;

   // A byte of four transparent pixels.
   localparam logic [7:0] ALL_TRANSPARENT = 8'h55;

   // Width of the glyph row counter; covers up to 32 rows.
   localparam int ROW_W = 5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERASE,
      ST_PIX_READ,
      ST_PIX_WRITE,
      ST_GLYPH_FETCH,
      ST_GLYPH_LATCH,
      ST_READ,
      ST_READ_DATA,
      ST_FINISH
   } state_type;

   // Maps a glyph pixel onto the frame code that it paints.
   function automatic logic [1:0] glyph_to_code(input logic [1:0] glyph);
      logic [1:0] code;
      case (glyph)
         GLYPH_BLACK: code = CODE_BLACK;
         GLYPH_WHITE: code = CODE_WHITE;
         default:     code = CODE_TRANSPARENT;
      endcase
      return code;
   endfunction

   // Picks pixel idx from a byte; pixel 0 sits in the top bits.
   function automatic logic [1:0] pixel_get(input logic [7:0] data, input logic [1:0] idx);
      logic [1:0] code;
      case (idx)
         2'd0:    code = data[7:6];
         2'd1:    code = data[5:4];
         2'd2:    code = data[3:2];
         default: code = data[1:0];
      endcase
      return code;
   endfunction

   // Replaces pixel idx of a byte with code.
   function automatic logic [7:0] pixel_put(input logic [7:0] data, input logic [1:0] idx,
                                            input logic [1:0] code);
      logic [7:0] result;
      result = data;
      case (idx)
         2'd0:    result[7:6] = code;
         2'd1:    result[5:4] = code;
         2'd2:    result[3:2] = code;
         default: result[1:0] = code;
      endcase
      return result;
   endfunction

endpackage

FILE: rtl/osdfb_req_if.sv
interface osdfb_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [9:0]  x;
   logic [8:0]  y;
   logic [1:0]  pixel_mode;
   logic [13:0] font_address;
   logic [7:0]  font_byte;
   logic [7:0]  char_index;

   modport source (
      output valid, kind, x, y, pixel_mode, font_address, font_byte, char_index,
      input  ready
   );

   modport sink (
      input  valid, kind, x, y, pixel_mode, font_address, font_byte, char_index,
      output ready
   );
endinterface

FILE: rtl/osdfb_rsp_if.sv
interface osdfb_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] pixel_first;
   logic [1:0] pixel_second;
   logic [1:0] pixel_third;
   logic [1:0] pixel_fourth;
   logic       status;

   modport source (
      output valid, pixel_first, pixel_second, pixel_third, pixel_fourth, status,
      input  ready
   );

   modport sink (
      input  valid, pixel_first, pixel_second, pixel_third, pixel_fourth, status,
      output ready
   );
endinterface

FILE: rtl/osd_frame_buffer_glyph_engine.sv
// On-screen-display frame store, 2 bits per pixel, with glyph drawing.
// Requests arrive on req_chan (valid/ready); each accepted word yields exactly one
// response word on rsp_chan. Only read byte returns pixel data; every kind reports
// in status whether some access fell outside the frame or font store.
// One command is in flight at a time; the frame and font stores are single-port
// memories with a registered read, and each pixel update is a read then a write on
// the frame port; a clipped pixel skips the write. Font load and unused kinds go
// straight to finish; erase writes one frame byte per cycle over the whole frame;
// draw character fetches and latches each font byte of a glyph row, then updates
// its four pixels in turn.
// A new request is taken in the cycle that the previous response is registered, so
// back-to-back font loads run at one word per cycle while rsp_chan.ready stays high.
// The response register holds its word while rsp_chan.ready is low; the engine then
// finishes its current command and waits with the next response; a request is still
// accepted while idle with a response waiting, but not while the next one waits.
// Reset empties the response register and returns the engine to idle. The stores
// are not cleared: frame contents are undefined until an erase or a write.
module osd_frame_buffer_glyph_engine #(
   parameter int LINE_PIXELS = 512,
   parameter int FRAME_LINES = 288,
   parameter int GLYPH_BYTES = 64,
   parameter int GLYPH_ROWS  = 18
) (
   input logic          clock,
   input logic          reset,
   osdfb_req_if.sink    req_chan,
   osdfb_rsp_if.source  rsp_chan
);

   import osdfb_pkg::*;

   localparam int LINE_BYTES = (LINE_PIXELS + 3) / 4;
   localparam int FRAME_SIZE = LINE_BYTES * FRAME_LINES;
   localparam int FONT_SIZE  = 256 * GLYPH_BYTES;
   localparam int FRAME_AW   = $clog2(FRAME_SIZE);
   localparam int FONT_AW    = $clog2(FONT_SIZE);

   // Control and command registers.
   state_type            state_ff, state_in;
   logic [2:0]           kind_ff, kind_in;
   logic [9:0]           x_ff, x_in;
   logic [8:0]           y_ff, y_in;
   logic [1:0]           mode_ff, mode_in;
   logic [7:0]           ch_ff, ch_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [1:0]           b_ff, b_in;
   logic [1:0]           p_ff, p_in;
   logic [7:0]           glyph_ff, glyph_in;
   logic                 font_oob_ff, font_oob_in;
   logic                 status_ff, status_in;
   logic [7:0]           byte_ff, byte_in;
   logic [FRAME_AW-1:0]  erase_ff, erase_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                 frame_we;
   logic [FRAME_AW-1:0]  frame_addr;
   logic [7:0]           frame_wdata;
   logic [7:0]           frame_rdata;
   logic                 font_we;
   logic [FONT_AW-1:0]   font_addr;
   logic [7:0]           font_rdata;

   // Address arithmetic.
   logic [10:0]          px;
   logic [9:0]           py;
   logic [19:0]          pix_lin;
   logic                 pix_in_frame;
   logic                 read_in_frame;
   logic [14:0]          glyph_addr;
   logic                 glyph_in_font;
   logic                 load_in_font;
   logic                 is_draw;
   logic [1:0]           pix_code;
   logic                 out_free;
   logic                 accept;

   // Pixel walk advance after one glyph pixel.
   state_type            adv_state;
   logic [ROW_W-1:0]     adv_row;
   logic [1:0]           adv_b;
   logic [1:0]           adv_p;

   osdfb_spram #(.WIDTH(8), .DEPTH(FRAME_SIZE)) u_frame_ram (
      .clock (clock),
      .we    (frame_we),
      .addr  (frame_addr),
      .wdata (frame_wdata),
      .rdata (frame_rdata)
   );

   osdfb_spram #(.WIDTH(8), .DEPTH(FONT_SIZE)) u_font_ram (
      .clock (clock),
      .we    (font_we),
      .addr  (font_addr),
      .wdata (req_chan.font_byte),
      .rdata (font_rdata)
   );

   // Position of the current pixel: the glyph offsets are zero for set pixel and read.
   assign px      = 11'(x_ff) + 11'({b_ff, p_ff});
   assign py      = 10'(y_ff) + 10'(row_ff);
   assign pix_lin = 20'(py) * 20'(LINE_BYTES) + 20'(px[10:2]);

   assign pix_in_frame  = (px < 11'(LINE_PIXELS)) && (py < 10'(FRAME_LINES));
   assign read_in_frame = (9'(x_ff[9:2]) < 9'(LINE_BYTES)) && (10'(y_ff) < 10'(FRAME_LINES));

   // Font byte of the current glyph row and byte column.
   assign glyph_addr    = 15'(ch_ff) * 15'(GLYPH_BYTES) + 15'(row_ff) * 15'd3 + 15'(b_ff);
   assign glyph_in_font = glyph_addr < 15'(FONT_SIZE);
   assign load_in_font  = 15'(req_chan.font_address) < 15'(FONT_SIZE);

   assign is_draw  = (kind_ff == KIND_DRAW_CHAR);
   assign pix_code = is_draw ? glyph_to_code(pixel_get(glyph_ff, p_ff)) : mode_ff;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free);
   assign accept         = req_chan.valid && req_chan.ready;

   // Step to the next glyph pixel, the next font byte or the next row.
   always_comb begin
      adv_state = ST_PIX_READ;
      adv_row   = row_ff;
      adv_b     = b_ff;
      adv_p     = p_ff + 2'd1;
      if (!is_draw) begin
         adv_state = ST_FINISH;
         adv_p     = p_ff;
      end else if (p_ff == 2'd3) begin
         adv_p     = 2'd0;
         adv_state = ST_GLYPH_FETCH;
         if (b_ff == 2'd2) begin
            adv_b = 2'd0;
            if (row_ff == ROW_W'(GLYPH_ROWS - 1)) begin
               adv_state = ST_FINISH;
            end else begin
               adv_row = row_ff + ROW_W'(1);
            end
         end else begin
            adv_b = b_ff + 2'd1;
         end
      end
   end

   // Next state, memory control and the response register.
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      mode_in       = mode_ff;
      ch_in         = ch_ff;
      row_in        = row_ff;
      b_in          = b_ff;
      p_in          = p_ff;
      glyph_in      = glyph_ff;
      font_oob_in   = font_oob_ff;
      status_in     = status_ff;
      byte_in       = byte_ff;
      erase_in      = erase_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;

      frame_we    = 1'b0;
      frame_addr  = pix_lin[FRAME_AW-1:0];
      frame_wdata = pixel_put(frame_rdata, px[1:0], pix_code);
      font_we     = 1'b0;
      font_addr   = glyph_addr[FONT_AW-1:0];

      // The response register drains whenever the receiver takes the word.
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
         end

         ST_ERASE: begin
            frame_we    = 1'b1;
            frame_addr  = erase_ff;
            frame_wdata = ALL_TRANSPARENT;
            erase_in    = erase_ff + FRAME_AW'(1);
            if (erase_ff == FRAME_AW'(FRAME_SIZE - 1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_GLYPH_FETCH: begin
            font_oob_in = !glyph_in_font;
            state_in    = ST_GLYPH_LATCH;
         end

         ST_GLYPH_LATCH: begin
            glyph_in = font_oob_ff ? ALL_TRANSPARENT : font_rdata;
            state_in = ST_PIX_READ;
         end

         ST_PIX_READ: begin
            if (pix_in_frame) begin
               state_in = ST_PIX_WRITE;
            end else begin
               status_in = 1'b1;
               state_in  = adv_state;
               row_in    = adv_row;
               b_in      = adv_b;
               p_in      = adv_p;
            end
         end

         ST_PIX_WRITE: begin
            frame_we = 1'b1;
            state_in = adv_state;
            row_in   = adv_row;
            b_in     = adv_b;
            p_in     = adv_p;
         end

         ST_READ: begin
            if (read_in_frame) begin
               state_in = ST_READ_DATA;
            end else begin
               status_in = 1'b1;
               state_in  = ST_FINISH;
            end
         end

         ST_READ_DATA: begin
            byte_in  = frame_rdata;
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = byte_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Launch a new command; this overrides the idle transition out of finish.
      if (accept) begin
         kind_in     = req_chan.kind;
         x_in        = req_chan.x;
         y_in        = req_chan.y;
         mode_in     = req_chan.pixel_mode;
         ch_in       = req_chan.char_index;
         row_in      = '0;
         b_in        = 2'd0;
         p_in        = 2'd0;
         status_in   = 1'b0;
         byte_in     = 8'd0;
         erase_in    = '0;
         case (req_chan.kind)
            KIND_ERASE:     state_in = ST_ERASE;
            KIND_SET_PIXEL: state_in = ST_PIX_READ;
            KIND_FONT_LOAD: begin
               font_we   = load_in_font;
               font_addr = req_chan.font_address[FONT_AW-1:0];
               status_in = !load_in_font;
               state_in  = ST_FINISH;
            end
            KIND_DRAW_CHAR: state_in = ST_GLYPH_FETCH;
            KIND_READ_BYTE: state_in = ST_READ;
            default:        state_in = ST_FINISH;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and payload registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      mode_ff       <= mode_in;
      ch_ff         <= ch_in;
      row_ff        <= row_in;
      b_ff          <= b_in;
      p_ff          <= p_in;
      glyph_ff      <= glyph_in;
      font_oob_ff   <= font_oob_in;
      status_ff     <= status_in;
      byte_ff       <= byte_in;
      erase_ff      <= erase_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Response word.
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_first  = rsp_byte_ff[7:6];
   assign rsp_chan.pixel_second = rsp_byte_ff[5:4];
   assign rsp_chan.pixel_third  = rsp_byte_ff[3:2];
   assign rsp_chan.pixel_fourth = rsp_byte_ff[1:0];
   assign rsp_chan.status       = rsp_status_ff;

endmodule

FILE: rtl/osdfb_spram.sv
module osdfb_spram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: one optional write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: tb/osd_frame_buffer_glyph_engine_tb.sv
`timescale 1ns / 1ps

module osd_frame_buffer_glyph_engine_tb;
   import osdfb_pkg::*;

   localparam int LINE_PIXELS   = 512;
   localparam int FRAME_LINES   = 288;
   localparam int GLYPH_BYTES   = 64;
   localparam int GLYPH_ROWS    = 18;
   localparam int LINE_BYTES    = (LINE_PIXELS + 3) / 4;
   localparam int FRAME_BYTES   = LINE_BYTES * FRAME_LINES;
   localparam int FONT_BYTES    = 256 * GLYPH_BYTES;
   localparam int GLYPH_FETCHES = GLYPH_ROWS * 3;

   // Codes the package leaves unnamed.
   localparam logic [1:0] CODE_GREY    = 2'b10;
   localparam logic [2:0] KIND_SPARE_5 = 3'd5;
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   localparam int TOTAL_ITEMS   = 1320;
   localparam int HOLD_CYCLES   = 800;
   localparam int HOLD_SPACING  = 450;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 4_000_000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [2:0]  kind;
      logic [9:0]  x;
      logic [8:0]  y;
      logic [1:0]  pixel_mode;
      logic [13:0] font_address;
      logic [7:0]  font_byte;
      logic [7:0]  char_index;
      logic        drain_first;
   } osd_cmd_type;

   typedef struct packed {
      logic [1:0] pixel_first;
      logic [1:0] pixel_second;
      logic [1:0] pixel_third;
      logic [1:0] pixel_fourth;
      logic       status;
   } osd_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Free-running clock, 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   osdfb_req_if req_chan ();
   osdfb_rsp_if rsp_chan ();

   osd_frame_buffer_glyph_engine #(
      .LINE_PIXELS (LINE_PIXELS),
      .FRAME_LINES (FRAME_LINES),
      .GLYPH_BYTES (GLYPH_BYTES),
      .GLYPH_ROWS  (GLYPH_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copies of the stores, kept in step with accepted words.
   logic [7:0]  frame_model [FRAME_BYTES];
   logic [7:0]  font_model  [FONT_BYTES];
   logic [15:0] glyph_fetch_count = '0;

   osd_cmd_type  command_backlog [$];
   osd_word_type due_responses   [$];
   osd_cmd_type  cur_cmd;

   // Generation-time record of which font bytes have been loaded.
   bit font_written [FONT_BYTES];
   bit glyph_listed [256];
   int ready_glyphs [$];

   int  mismatch_count = 0;
   int  accepted_cmds  = 0;
   int  cycle_count    = 0;
   bit  offering       = 1'b0;
   int  send_gap       = 0;
   int  take_gap       = 0;
   bit  send_calm      = 1'b0;
   bit  take_calm      = 1'b0;
   logic hold_rsp      = 1'b0;
   int  hold_left      = 0;
   int  hold_rounds    = 0;

   // Paints one pixel into the frame shadow; returns 1 when it falls outside and is dropped.
   function automatic bit paint_pixel(input int px, input int py, input logic [1:0] code);
      int addr;
      int lane;
      if (px >= LINE_PIXELS || py >= FRAME_LINES)
         return 1'b1;
      addr = py * LINE_BYTES + px / 4;
      lane = 3 - px % 4;
      frame_model[addr][2 * lane +: 2] = code;
      return 1'b0;
   endfunction

   // Updates the shadow stores for one command and works out its response word.
   function automatic osd_word_type apply_command(input osd_cmd_type c);
      osd_word_type r;
      int          base;
      int          px;
      int          addr;
      int          col;
      logic [7:0]  fb;
      logic [1:0]  glyph;
      logic [1:0]  code;
      logic [15:0] fetched;
      r = '0;
      case (c.kind)
         KIND_ERASE: begin
            foreach (frame_model[i])
               frame_model[i] = ALL_TRANSPARENT;
         end
         KIND_SET_PIXEL: begin
            r.status = paint_pixel(c.x, c.y, c.pixel_mode);
         end
         KIND_FONT_LOAD: begin
            if (c.font_address < FONT_BYTES)
               font_model[c.font_address] = c.font_byte;
            else
               r.status = 1'b1;
         end
         KIND_DRAW_CHAR: begin
            base = c.char_index * GLYPH_BYTES;
            fetched = '0;
            for (int row = 0; row < GLYPH_ROWS; row++) begin
               px = c.x;
               for (int b = 0; b < 3; b++) begin
                  addr = base + row * 3 + b;
                  fb = (addr < FONT_BYTES) ? font_model[addr] : ALL_TRANSPARENT;
                  fetched++;
                  for (int p = 0; p < 4; p++) begin
                     glyph = fb[7 - 2 * p -: 2];
                     case (glyph)
                        GLYPH_BLACK: code = CODE_BLACK;
                        GLYPH_WHITE: code = CODE_WHITE;
                        default:     code = CODE_TRANSPARENT;
                     endcase
                     if (paint_pixel(px, c.y + row, code))
                        r.status = 1'b1;
                     px++;
                  end
               end
            end
            glyph_fetch_count = fetched;
         end
         KIND_READ_BYTE: begin
            col = c.x >> 2;
            if (col < LINE_BYTES && c.y < FRAME_LINES) begin
               fb = frame_model[c.y * LINE_BYTES + col];
               r.pixel_first  = fb[7:6];
               r.pixel_second = fb[5:4];
               r.pixel_third  = fb[3:2];
               r.pixel_fourth = fb[1:0];
            end else begin
               r.status = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Mostly random gaps, with runs where a side does not idle at all.
   function automatic int pick_gap(inout bit calm);
      if ($urandom_range(0, 24) == 0)
         calm = !calm;
      return calm ? 0 : $urandom_range(0, 13);
   endfunction

   task automatic report_failure(input string what);
      if (mismatch_count < REPORT_LIMIT)
         $display("%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // A word with every field random except the kind.
   function automatic osd_cmd_type make_cmd(input logic [2:0] kind);
      osd_cmd_type c;
      c.kind         = kind;
      c.x            = 10'($urandom);
      c.y            = 9'($urandom);
      c.pixel_mode   = 2'($urandom);
      c.font_address = 14'($urandom);
      c.font_byte    = 8'($urandom);
      c.char_index   = 8'($urandom);
      c.drain_first  = ($urandom_range(0, 59) == 0);
      return c;
   endfunction

   task automatic erase_frame(input bit drain);
      osd_cmd_type c;
      c = make_cmd(KIND_ERASE);
      c.drain_first = drain;
      command_backlog.push_back(c);
   endtask

   task automatic set_pixel(input int x, input int y, input logic [1:0] code);
      osd_cmd_type c;
      c = make_cmd(KIND_SET_PIXEL);
      c.x = 10'(x);
      c.y = 9'(y);
      c.pixel_mode = code;
      command_backlog.push_back(c);
   endtask

   task automatic read_at(input int x, input int y);
      osd_cmd_type c;
      c = make_cmd(KIND_READ_BYTE);
      c.x = 10'(x);
      c.y = 9'(y);
      command_backlog.push_back(c);
   endtask

   task automatic draw_at(input int ch, input int x, input int y);
      osd_cmd_type c;
      c = make_cmd(KIND_DRAW_CHAR);
      c.char_index = 8'(ch);
      c.x = 10'(x);
      c.y = 9'(y);
      command_backlog.push_back(c);
   endtask

   // Font load; a glyph becomes drawable once all of its fetched bytes are written.
   task automatic load_font(input int addr, input logic [7:0] data);
      osd_cmd_type c;
      int       ch;
      bit       complete;
      c = make_cmd(KIND_FONT_LOAD);
      c.font_address = 14'(addr);
      c.font_byte = data;
      command_backlog.push_back(c);
      font_written[addr] = 1'b1;
      ch = addr / GLYPH_BYTES;
      if (!glyph_listed[ch]) begin
         complete = 1'b1;
         for (int i = 0; i < GLYPH_FETCHES; i++)
            complete &= font_written[ch * GLYPH_BYTES + i];
         if (complete) begin
            glyph_listed[ch] = 1'b1;
            ready_glyphs.push_back(ch);
         end
      end
   endtask

   // Loads every byte a draw will fetch; the pattern mixes all four glyph codes.
   task automatic load_glyph(input int ch, input bit patterned);
      logic [7:0] data;
      for (int i = 0; i < GLYPH_FETCHES; i++) begin
         data = patterned ? 8'(32'hE4AA1B00 >> (8 * (i % 4))) : 8'($urandom);
         load_font(ch * GLYPH_BYTES + i, data);
      end
   endtask

   task automatic spare_kind();
      case ($urandom_range(0, 2))
         0:       command_backlog.push_back(make_cmd(KIND_SPARE_5));
         1:       command_backlog.push_back(make_cmd(KIND_SPARE_6));
         default: command_backlog.push_back(make_cmd(KIND_SPARE_7));
      endcase
   endtask

   // Request driver: predicts each word as it is accepted, then offers the next.
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            due_responses.push_back(apply_command(cur_cmd));
            accepted_cmds <= accepted_cmds + 1;
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (command_backlog.size() != 0 &&
                         !(command_backlog[0].drain_first && due_responses.size() != 0)) begin
               cur_cmd = command_backlog.pop_front();
               req_chan.kind         <= cur_cmd.kind;
               req_chan.x            <= cur_cmd.x;
               req_chan.y            <= cur_cmd.y;
               req_chan.pixel_mode   <= cur_cmd.pixel_mode;
               req_chan.font_address <= cur_cmd.font_address;
               req_chan.font_byte    <= cur_cmd.font_byte;
               req_chan.char_index   <= cur_cmd.char_index;
               offering = 1'b1;
               send_gap = pick_gap(send_calm);
            end
         end
         req_chan.valid <= offering;
      end
   end

   // Response monitor: checks each word against the oldest prediction.
   always @(posedge clock) begin
      osd_word_type got;
      osd_word_type want;
      if (reset) begin
         take_gap = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pixel_first  = rsp_chan.pixel_first;
            got.pixel_second = rsp_chan.pixel_second;
            got.pixel_third  = rsp_chan.pixel_third;
            got.pixel_fourth = rsp_chan.pixel_fourth;
            got.status       = rsp_chan.status;
            if (due_responses.size() == 0) begin
               report_failure("response word arrived with nothing expected");
            end else begin
               want = due_responses.pop_front();
               if (got !== want)
                  report_failure($sformatf(
                     "expected %0d %0d %0d %0d status %0d, got %0d %0d %0d %0d status %0d",
                     want.pixel_first, want.pixel_second, want.pixel_third,
                     want.pixel_fourth, want.status, got.pixel_first, got.pixel_second,
                     got.pixel_third, got.pixel_fourth, got.status));
            end
            take_gap = pick_gap(take_calm);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !hold_rsp;
         end
      end
   end

   // Long back-pressure spells so that the engine fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         hold_rsp <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         if (hold_left == 0)
            hold_rsp <= 1'b0;
      end else if (hold_rounds < 2 && accepted_cmds >= (hold_rounds + 1) * HOLD_SPACING) begin
         hold_left = HOLD_CYCLES;
         hold_rounds++;
         hold_rsp <= 1'b1;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL osd_frame_buffer_glyph_engine");
         $finish;
      end
   end

   initial begin
      int roll;
      int x;
      int y;
      int erases_left;
      int last_x;
      int last_y;

      req_chan.valid        = 1'b0;
      req_chan.kind         = KIND_ERASE;
      req_chan.x            = '0;
      req_chan.y            = '0;
      req_chan.pixel_mode   = '0;
      req_chan.font_address = '0;
      req_chan.font_byte    = '0;
      req_chan.char_index   = '0;
      rsp_chan.ready        = 1'b0;

      // Directed part: corners, every pixel code, clipping, spare kinds.
      erase_frame(1'b1);
      read_at(0, 0);
      set_pixel(0, 0, CODE_BLACK);
      set_pixel(1, 0, CODE_GREY);
      set_pixel(2, 0, CODE_WHITE);
      set_pixel(3, 0, CODE_TRANSPARENT);
      read_at(3, 0);
      set_pixel(LINE_PIXELS - 1, FRAME_LINES - 1, CODE_WHITE);
      read_at(LINE_PIXELS - 4, FRAME_LINES - 1);
      set_pixel(LINE_PIXELS, 0, CODE_GREY);
      set_pixel(0, FRAME_LINES, CODE_BLACK);
      set_pixel(1023, 511, CODE_WHITE);
      read_at(1023, 511);
      read_at(LINE_PIXELS, 0);
      read_at(0, FRAME_LINES);
      load_font(FONT_BYTES - 1, 8'hFF);
      load_font(0, 8'h00);
      command_backlog.push_back(make_cmd(KIND_SPARE_5));
      command_backlog.push_back(make_cmd(KIND_SPARE_6));
      command_backlog.push_back(make_cmd(KIND_SPARE_7));
      erase_frame(1'b1);
      read_at(0, 0);

      // Two glyphs, then draws inside, across the corner and wholly outside the frame.
      load_glyph(0, 1'b1);
      load_glyph(255, 1'b0);
      draw_at(0, 0, 0);
      read_at(0, 0);
      read_at(4, 0);
      read_at(8, GLYPH_ROWS - 1);
      draw_at(255, LINE_PIXELS - 6, FRAME_LINES - 9);
      read_at(LINE_PIXELS - 4, FRAME_LINES - 1);
      draw_at(0, 1023, 511);

      // Random part: mostly well-formed glyph work around the last drawn spot.
      erases_left = 4;
      last_x = 0;
      last_y = 0;
      while (command_backlog.size() < TOTAL_ITEMS) begin
         roll = $urandom_range(0, 999);
         if (roll < 5 && erases_left > 0) begin
            erase_frame($urandom_range(0, 1));
            erases_left--;
         end else if (roll < 20 || (roll >= 50 && roll < 190 && ready_glyphs.size() == 0)) begin
            load_glyph($urandom_range(0, 255), 1'b0);
         end else if (roll < 50) begin
            load_font($urandom_range(0, FONT_BYTES - 1), 8'($urandom));
         end else if (roll < 190) begin
            case ($urandom_range(0, 19))
               0, 1, 2: begin
                  x = $urandom_range(0, 1023);
                  y = $urandom_range(0, 511);
               end
               3, 4, 5: begin
                  x = LINE_PIXELS - $urandom_range(1, 12);
                  y = $urandom_range(0, FRAME_LINES - 1);
               end
               6, 7: begin
                  x = $urandom_range(0, LINE_PIXELS - 1);
                  y = FRAME_LINES - $urandom_range(1, GLYPH_ROWS);
               end
               default: begin
                  x = $urandom_range(0, LINE_PIXELS - 1);
                  y = $urandom_range(0, FRAME_LINES - 1);
               end
            endcase
            draw_at(ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)], x, y);
            last_x = x;
            last_y = y;
         end else if (roll < 230) begin
            spare_kind();
         end else begin
            // Set pixels and reads: near the last glyph, anywhere in frame, or anywhere.
            case ($urandom_range(0, 9))
               0, 1: begin
                  x = $urandom_range(0, 1023);
                  y = $urandom_range(0, 511);
               end
               2, 3, 4: begin
                  x = $urandom_range(0, LINE_PIXELS - 1);
                  y = $urandom_range(0, FRAME_LINES - 1);
               end
               default: begin
                  x = (last_x + $urandom_range(0, 15)) % 1024;
                  y = (last_y + $urandom_range(0, GLYPH_ROWS - 1)) % 512;
               end
            endcase
            if (roll < 600)
               set_pixel(x, y, 2'($urandom));
            else
               read_at(x, y);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every word to be accepted and every response to be checked.
      while (command_backlog.size() != 0 || offering)
         @(posedge clock);
      while (due_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && due_responses.size() == 0)
         $display("PASS osd_frame_buffer_glyph_engine");
      else
         $display("FAIL osd_frame_buffer_glyph_engine");
      $finish;
   end

endmodule

FILE: osd_frame_buffer_glyph_engine.f
rtl/osdfb_pkg.sv
rtl/osdfb_req_if.sv
rtl/osdfb_rsp_if.sv
rtl/osdfb_spram.sv
rtl/osd_frame_buffer_glyph_engine.sv
tb/osd_frame_buffer_glyph_engine_tb.sv
